### rtl/sibs_pkg.sv
// ----------------------------------------------------------------------------
// sibs_pkg: shared types and constants of the sorted index search block
// Item codes, field widths and the command/status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package sibs_pkg;

    localparam int KEY_W        = 32;
    localparam int OFFSET_W     = 31;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 32;
    localparam int ENTRY_W      = KEY_W + OFFSET_W;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic    load_search;
        logic    append;
        logic    clear;
        logic    step;
        logic    rd_en;
        logic    set_res;
        logic    res_found;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic range_open;
        logic key_eq;
    } stat_t;

endpackage

### rtl/sibs_ram.sv
// ----------------------------------------------------------------------------
// sibs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module sibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sibs_datapath.sv
// ----------------------------------------------------------------------------
// sibs_datapath: index table, search bounds and result registers
// Holds the entry count, the search key and the inclusive-low/exclusive-high
// bounds; forms the probe address and compares the probed key.
// ----------------------------------------------------------------------------
module sibs_datapath #(
    parameter int TABLE_DEPTH = sibs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sibs_pkg::cmd_t                 cmd,
    output sibs_pkg::stat_t                stat,
    input  logic [sibs_pkg::S_TDATA_W-1:0] in_data,
    output logic [sibs_pkg::STATUS_W-1:0]  res_status,
    output logic [sibs_pkg::OFFSET_W-1:0]  res_offset
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W   = sibs_pkg::KEY_W;
    localparam int OFF_W   = sibs_pkg::OFFSET_W;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] lo_reg, lo_next;
    logic [COUNT_W-1:0] hi_reg, hi_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [sibs_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [OFF_W-1:0]   res_offset_reg, res_offset_next;

    logic [COUNT_W:0]   mid_sum;
    logic [ADDR_W-1:0]  mid;
    logic [sibs_pkg::ENTRY_W-1:0] wr_data;
    logic [sibs_pkg::ENTRY_W-1:0] rd_data;
    logic [KEY_W-1:0]   probe_key;
    logic [OFF_W-1:0]   probe_offset;
    logic               key_lt;

    // floored midpoint of lo and hi-1 (inclusive high bound)
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (COUNT_W+1)'(1);
    assign mid     = mid_sum[ADDR_W:1];

    assign wr_data = in_data[sibs_pkg::ENTRY_W-1:0];

    sibs_ram #(
        .WIDTH (sibs_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.append),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (mid),
        .rd_data (rd_data)
    );

    assign probe_key    = rd_data[KEY_W-1:0];
    assign probe_offset = rd_data[sibs_pkg::ENTRY_W-1:KEY_W];
    assign key_lt       = $signed(probe_key) < $signed(key_reg);

    assign stat.full       = (count_reg == COUNT_W'(TABLE_DEPTH));
    assign stat.range_open = (lo_reg < hi_reg);
    assign stat.key_eq     = (probe_key == key_reg);

    always_comb begin
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        if (cmd.append) begin
            count_next = count_reg + COUNT_W'(1);
        end
        if (cmd.clear) begin
            count_next = '0;
        end
        if (cmd.load_search) begin
            key_next = in_data[KEY_W-1:0];
            lo_next  = '0;
            hi_next  = count_reg;
        end
        if (cmd.step) begin
            if (key_lt) begin
                lo_next = COUNT_W'(mid) + COUNT_W'(1);
            end else begin
                hi_next = COUNT_W'(mid);
            end
        end
        if (cmd.set_res) begin
            res_status_next = cmd.res_status;
            res_offset_next = cmd.res_found ? probe_offset : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
    end

    assign res_status = res_status_reg;
    assign res_offset = res_offset_reg;

endmodule

### rtl/sibs_ctrl.sv
// ----------------------------------------------------------------------------
// sibs_ctrl: item sequencer of the sorted index search block
// Decodes each item, walks the probe loop (read, then compare) and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module sibs_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sibs_pkg::OPCODE_W-1:0] opcode,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output sibs_pkg::cmd_t                cmd,
    input  sibs_pkg::stat_t               stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = sibs_pkg::ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next  = S_OUT;
                    cmd.set_res = 1'b1;
                    case (opcode)
                        sibs_pkg::OP_APPEND: begin
                            if (stat.full) begin
                                cmd.res_status = sibs_pkg::ST_FULL;
                            end else begin
                                cmd.append = 1'b1;
                            end
                        end
                        sibs_pkg::OP_SEARCH: begin
                            cmd.set_res     = 1'b0;
                            cmd.load_search = 1'b1;
                            state_next      = S_READ;
                        end
                        sibs_pkg::OP_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        default: begin
                            // unused code: answer ok, leave the table alone
                        end
                    endcase
                end
            end
            S_READ: begin
                if (stat.range_open) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CMP;
                end else begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = sibs_pkg::ST_NOT_FOUND;
                    state_next     = S_OUT;
                end
            end
            S_CMP: begin
                if (stat.key_eq) begin
                    cmd.set_res   = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = (state_next == S_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid     <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

### rtl/sorted_index_binary_search.sv
// ----------------------------------------------------------------------------
// An append, clear or opcode-3 item can be taken from the output in the cycle
// after it was accepted. A search result can be taken once the probe loop
// ends: after the compare of a matching probe when the key is found, or after
// one more S_READ visit that finds the range empty when it is missing. At most
// ceil(log2(n+1)) probes are made for n stored entries, so 11 at 1024. Each
// probe is a registered table read (S_READ) followed by the signed compare and
// bound update (S_CMP). The block works on one item at a time and takes the
// next item in the cycle after the result is taken.
// ----------------------------------------------------------------------------
// sorted_index_binary_search: index table with binary search
// Holds (key, record offset) pairs loaded in ascending key order and answers
// searches with the offset of the first matching probe.
// ----------------------------------------------------------------------------
module sorted_index_binary_search #(
    parameter int TABLE_DEPTH = sibs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key [31:0], record_offset [62:32], zero [63]
    input  logic [sibs_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode [1:0]
    input  logic [sibs_pkg::OPCODE_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found_offset [30:0], zero [31]
    output logic [sibs_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [sibs_pkg::STATUS_W-1:0]  m_tuser
);

    sibs_pkg::cmd_t  cmd;
    sibs_pkg::stat_t stat;
    logic [sibs_pkg::OFFSET_W-1:0] res_offset;

    sibs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sibs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (s_tdata),
        .res_status (m_tuser),
        .res_offset (res_offset)
    );

    assign m_tdata = {1'b0, res_offset};

endmodule

### rtl/sibs_checker.sv
// ----------------------------------------------------------------------------
// sibs_checker: port-level checks of the sorted index search block
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module sibs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sibs_pkg::OPCODE_W-1:0]  s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sibs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sibs_pkg::STATUS_W-1:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // never take a new item while a result is pending
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // non-search items answer on the next cycle
    a_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != sibs_pkg::OP_SEARCH) |=> m_tvalid)
        else $error("non-search item did not answer at once");

    // offset is zero whenever the status is not ok
    a_zero_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != sibs_pkg::ST_OK) |-> m_tdata == '0)
        else $error("offset non-zero on miss or full");

endmodule

bind sorted_index_binary_search sibs_checker u_sibs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
